// File: rtl/core/circle_pair_collision_resolver_core_assert.svh
// Assertion macros for the circle pair collision resolver core.
// Depends on nothing; included by the files that assert.
`ifndef CIRCLE_PAIR_COLLISION_RESOLVER_CORE_ASSERT_SVH
`define CIRCLE_PAIR_COLLISION_RESOLVER_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define CPCR_ASSERT_HOLD(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// condition in one cycle implies consequence in the next
`define CPCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/cpcr_pkg.sv
// Shared types and constants of the circle pair collision resolver.
// No dependencies; used by the channel interfaces and the core.
package cpcr_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_NUDGE_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUDGE_Y = 4'd1;

    localparam logic [CFG_DATA_W-1:0] NUDGE_RESET = 16'd16384;

    typedef struct packed {
        logic signed [31:0] pos_a_x;
        logic signed [31:0] pos_a_y;
        logic signed [31:0] vel_a_x;
        logic signed [31:0] vel_a_y;
        logic [31:0]        mass_a;
        logic [30:0]        radius_a;
        logic signed [31:0] pos_b_x;
        logic signed [31:0] pos_b_y;
        logic signed [31:0] vel_b_x;
        logic signed [31:0] vel_b_y;
        logic [31:0]        mass_b;
        logic [30:0]        radius_b;
    } pair_t;

    typedef struct packed {
        logic               collided;
        logic signed [31:0] new_pos_a_x;
        logic signed [31:0] new_pos_a_y;
        logic signed [31:0] new_vel_a_x;
        logic signed [31:0] new_vel_a_y;
        logic signed [31:0] new_pos_b_x;
        logic signed [31:0] new_pos_b_y;
        logic signed [31:0] new_vel_b_x;
        logic signed [31:0] new_vel_b_y;
    } result_t;

endpackage

// File: rtl/core/cpcr_pair_if.sv
// Request channel carrying one pair of bodies.
// Depends on cpcr_pkg.
interface cpcr_pair_if import cpcr_pkg::*; ();
    logic  valid;
    logic  ready;
    pair_t payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

// File: rtl/core/cpcr_result_if.sv
// Result channel carrying the resolved pair.
// Depends on cpcr_pkg.
interface cpcr_result_if import cpcr_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

// File: rtl/core/cpcr_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on cpcr_pkg.
interface cpcr_cfg_if import cpcr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// File: rtl/core/circle_pair_collision_resolver_core.sv
// Channel      | Dir | Payload
// pair_in      | in  | pair_t: positions, velocities, masses, radii of A and B
// result_out   | out | result_t: collided flag and updated A and B state
// cfg          | in  | register index and 16-bit data (nudge_x, nudge_y)
//
// One pair enters per cycle while the output buffer does not hold the pipeline.
// The depth is set by the 32-stage square root and the 32-stage dividers for the
// unit vector and mass weights, followed by seven multiply and round stages.
// Reset clears valid bits and loads both nudges with 0.25; there is no clearing pass.
// A two-entry output buffer holds results; the whole pipeline holds while its
// second entry is full, and nothing is dropped or repeated.
// Depends on cpcr_pkg, the channel interfaces and the assertion macro header.
`include "circle_pair_collision_resolver_core_assert.svh"

module circle_pair_collision_resolver_core import cpcr_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    cpcr_pair_if.sink     pair_in,
    cpcr_result_if.source result_out,
    cpcr_cfg_if.sink      cfg
);

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 32;
    localparam int NSTG      = 3 + (SQ_STEPS + 1) + (DIV_STEPS + 1) + 7;

    localparam int LN_UX = 0;
    localparam int LN_UY = 1;
    localparam int LN_WA = 2;
    localparam int LN_WB = 3;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] avx;
        logic signed [31:0] avy;
        logic signed [31:0] bvx;
        logic signed [31:0] bvy;
        logic [31:0]        rs;
        logic [31:0]        ma;
        logic [31:0]        mb;
        logic               coinc;
        logic               hit;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
    } carry_t;

    typedef struct packed {
        carry_t      c;
        logic [31:0] mdx;
        logic [31:0] mdy;
    } s2_t;

    typedef struct packed {
        carry_t      c;
        logic [63:0] sqx;
        logic [63:0] sqy;
        logic [63:0] rsq;
    } s3_t;

    typedef struct packed {
        carry_t      c;
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } sq_t;

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] quo;
        logic [31:0] nlo;
        logic [32:0] den;
    } lane_t;

    typedef struct packed {
        carry_t      c;
        logic [31:0] d;
        logic        dzero;
        logic        tzero;
        lane_t [3:0] ln;
    } dv_t;

    typedef struct packed {
        carry_t             c;
        logic [31:0]        d;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic [31:0]        wa;
        logic [31:0]        wb;
    } p1_t;

    typedef struct packed {
        carry_t             c;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic [31:0]        wa;
        logic [31:0]        wb;
        logic signed [63:0] pax;
        logic signed [63:0] pay;
        logic signed [63:0] pbx;
        logic signed [63:0] pby;
        logic signed [33:0] m;
    } p2_t;

    typedef struct packed {
        carry_t             c;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic [31:0]        wa;
        logic [31:0]        wb;
        logic signed [33:0] m;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
    } p3_t;

    typedef struct packed {
        carry_t             c;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [33:0] m;
        logic signed [65:0] pda;
        logic signed [65:0] pdb;
    } p4_t;

    typedef struct packed {
        carry_t             c;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [33:0] m;
        logic signed [35:0] da;
        logic signed [35:0] db;
    } p5_t;

    typedef struct packed {
        carry_t             c;
        logic signed [67:0] dax;
        logic signed [67:0] day;
        logic signed [67:0] dbx;
        logic signed [67:0] dby;
        logic signed [67:0] pmx;
        logic signed [67:0] pmy;
    } p6_t;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
        logic signed [31:0] r;
        if (x > 40'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (x < -40'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [39:0] rnd30(input logic signed [67:0] x);
        logic signed [67:0] t;
        t = (x + 68'sd536870912) >>> 30;
        return t[39:0];
    endfunction

    function automatic logic signed [31:0] addsat(input logic signed [31:0] a,
                                                  input logic signed [39:0] b);
        logic signed [39:0] s;
        s = 40'(a) + b;
        return sat32(s);
    endfunction

    function automatic sq_t sq_step(input sq_t s);
        sq_t         n;
        logic [33:0] r2;
        logic [33:0] trial;
        logic        ge;
        n     = s;
        r2    = {s.rem[31:0], s.rad[63:62]};
        trial = {s.root, 2'b01};
        ge    = (r2 >= trial);
        n.rem  = ge ? (r2 - trial) : r2;
        n.root = {s.root[30:0], ge};
        n.rad  = {s.rad[61:0], 2'b00};
        return n;
    endfunction

    function automatic lane_t lane_init(input logic [63:0] num, input logic [32:0] den);
        lane_t l;
        l.rem = {1'b0, num[63:32]};
        l.quo = '0;
        l.nlo = num[31:0];
        l.den = den;
        return l;
    endfunction

    function automatic lane_t lane_step(input lane_t l);
        lane_t       n;
        logic [33:0] r2;
        logic [33:0] diff;
        logic        ge;
        n    = l;
        r2   = {l.rem, l.nlo[31]};
        diff = r2 - {1'b0, l.den};
        ge   = (r2 >= {1'b0, l.den});
        n.rem = ge ? diff[32:0] : r2[32:0];
        n.quo = {l.quo[30:0], ge};
        n.nlo = {l.nlo[30:0], 1'b0};
        return n;
    endfunction

    logic [CFG_DATA_W-1:0] nudge_x_reg;
    logic [CFG_DATA_W-1:0] nudge_y_reg;

    logic            en;
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;

    carry_t  s1_reg,  s1_next;
    s2_t     s2_reg,  s2_next;
    s3_t     s3_reg,  s3_next;
    sq_t     sq_reg [SQ_STEPS+1];
    sq_t     sq0_next;
    dv_t     dv_reg [DIV_STEPS+1];
    dv_t     dv0_next;
    p1_t     p1_reg,  p1_next;
    p2_t     p2_reg,  p2_next;
    p3_t     p3_reg,  p3_next;
    p4_t     p4_reg,  p4_next;
    p5_t     p5_reg,  p5_next;
    p6_t     p6_reg,  p6_next;
    result_t p7_reg,  p7_next;

    result_t out_reg;
    result_t skid_reg;
    logic    out_v_reg;
    logic    skid_v_reg;
    logic    push;
    logic    out_fire;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nudge_x_reg <= NUDGE_RESET;
            nudge_y_reg <= NUDGE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_NUDGE_X: nudge_x_reg <= cfg.data;
                REG_NUDGE_Y: nudge_y_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // pipeline control
    assign en            = !skid_v_reg;
    assign pair_in.ready = en;
    assign vld_next      = {vld_reg[NSTG-2:0], pair_in.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: nudge coincident centers, radius sum
    always_comb
    begin
        logic               coinc;
        logic signed [31:0] bxn;
        logic signed [31:0] byn;
        pair_t              p;
        p     = pair_in.payload;
        coinc = (p.pos_a_x == p.pos_b_x) && (p.pos_a_y == p.pos_b_y);
        bxn   = sat32({{8{p.pos_b_x[31]}}, p.pos_b_x} + {24'd0, nudge_x_reg});
        byn   = sat32({{8{p.pos_b_y[31]}}, p.pos_b_y} + {24'd0, nudge_y_reg});
        s1_next.ax    = p.pos_a_x;
        s1_next.ay    = p.pos_a_y;
        s1_next.bx    = coinc ? bxn : p.pos_b_x;
        s1_next.by    = coinc ? byn : p.pos_b_y;
        s1_next.avx   = p.vel_a_x;
        s1_next.avy   = p.vel_a_y;
        s1_next.bvx   = p.vel_b_x;
        s1_next.bvy   = p.vel_b_y;
        s1_next.rs    = {1'b0, p.radius_a} + {1'b0, p.radius_b};
        s1_next.ma    = p.mass_a;
        s1_next.mb    = p.mass_b;
        s1_next.coinc = coinc;
        s1_next.hit   = 1'b0;
        s1_next.dx    = '0;
        s1_next.dy    = '0;
    end

    // stage 2: direction and magnitudes
    always_comb
    begin
        logic signed [32:0] dxw;
        logic signed [32:0] dyw;
        logic signed [32:0] ndx;
        logic signed [32:0] ndy;
        dxw = 33'(s1_reg.ax) - 33'(s1_reg.bx);
        dyw = 33'(s1_reg.ay) - 33'(s1_reg.by);
        ndx = -dxw;
        ndy = -dyw;
        s2_next.c    = s1_reg;
        s2_next.c.dx = dxw;
        s2_next.c.dy = dyw;
        s2_next.mdx  = dxw[32] ? ndx[31:0] : dxw[31:0];
        s2_next.mdy  = dyw[32] ? ndy[31:0] : dyw[31:0];
    end

    // stage 3: squares
    always_comb
    begin
        s3_next.c   = s2_reg.c;
        s3_next.sqx = s2_reg.mdx * s2_reg.mdx;
        s3_next.sqy = s2_reg.mdy * s2_reg.mdy;
        s3_next.rsq = s2_reg.c.rs * s2_reg.c.rs;
    end

    // stage 4: overlap test, square root seed
    always_comb
    begin
        logic [64:0] sum;
        sum = {1'b0, s3_reg.sqx} + {1'b0, s3_reg.sqy};
        sq0_next       = '0;
        sq0_next.c     = s3_reg.c;
        sq0_next.c.hit = s3_reg.c.coinc || (sum <= {1'b0, s3_reg.rsq});
        sq0_next.rad   = sum[64] ? '1 : sum[63:0];
    end

    // divider seed: unit vector and mass weights
    always_comb
    begin
        logic [31:0] d;
        logic [32:0] ndx;
        logic [32:0] ndy;
        logic [31:0] mx;
        logic [31:0] my;
        logic [32:0] total;
        logic [63:0] nux;
        logic [63:0] nuy;
        logic [63:0] nwa;
        logic [63:0] nwb;
        carry_t      c;
        c     = sq_reg[SQ_STEPS].c;
        d     = sq_reg[SQ_STEPS].root;
        ndx   = -c.dx;
        ndy   = -c.dy;
        mx    = c.dx[32] ? ndx[31:0] : c.dx[31:0];
        my    = c.dy[32] ? ndy[31:0] : c.dy[31:0];
        total = {1'b0, c.ma} + {1'b0, c.mb};
        nux   = {2'b00, mx, 30'd0} + {33'd0, d[31:1]};
        nuy   = {2'b00, my, 30'd0} + {33'd0, d[31:1]};
        nwa   = {1'b0, c.ma, 31'd0} + {32'd0, total[32:1]};
        nwb   = {1'b0, c.mb, 31'd0} + {32'd0, total[32:1]};
        dv0_next.c         = c;
        dv0_next.d         = d;
        dv0_next.dzero     = (d == '0);
        dv0_next.tzero     = (total == '0);
        dv0_next.ln[LN_UX] = lane_init(nux, {1'b0, d});
        dv0_next.ln[LN_UY] = lane_init(nuy, {1'b0, d});
        dv0_next.ln[LN_WA] = lane_init(nwa, total);
        dv0_next.ln[LN_WB] = lane_init(nwb, total);
    end

    // post 1: signed unit vector, weights
    always_comb
    begin
        dv_t         v;
        logic [31:0] qx;
        logic [31:0] qy;
        v  = dv_reg[DIV_STEPS];
        qx = v.ln[LN_UX].quo;
        qy = v.ln[LN_UY].quo;
        p1_next.c  = v.c;
        p1_next.d  = v.d;
        p1_next.ux = v.dzero ? '0 : (v.c.dx[32] ? -$signed(qx) : $signed(qx));
        p1_next.uy = v.dzero ? '0 : (v.c.dy[32] ? -$signed(qy) : $signed(qy));
        p1_next.wa = v.tzero ? 32'h4000_0000 : v.ln[LN_WA].quo;
        p1_next.wb = v.tzero ? 32'h4000_0000 : v.ln[LN_WB].quo;
    end

    // post 2: projections and push amount
    always_comb
    begin
        logic signed [33:0] tm;
        tm = $signed({2'b00, p1_reg.c.rs}) - $signed({2'b00, p1_reg.d});
        p2_next.c   = p1_reg.c;
        p2_next.ux  = p1_reg.ux;
        p2_next.uy  = p1_reg.uy;
        p2_next.wa  = p1_reg.wa;
        p2_next.wb  = p1_reg.wb;
        p2_next.pax = p1_reg.c.avx * p1_reg.ux;
        p2_next.pay = p1_reg.c.avy * p1_reg.uy;
        p2_next.pbx = p1_reg.c.bvx * p1_reg.ux;
        p2_next.pby = p1_reg.c.bvy * p1_reg.uy;
        p2_next.m   = (tm >>> 2) + 34'sd32768;
    end

    // post 3: speeds along the line
    always_comb
    begin
        logic signed [63:0] ta;
        logic signed [63:0] tb;
        ta = (p2_reg.pax + p2_reg.pay + 64'sd536870912) >>> 30;
        tb = (p2_reg.pbx + p2_reg.pby + 64'sd536870912) >>> 30;
        p3_next.c  = p2_reg.c;
        p3_next.ux = p2_reg.ux;
        p3_next.uy = p2_reg.uy;
        p3_next.wa = p2_reg.wa;
        p3_next.wb = p2_reg.wb;
        p3_next.m  = p2_reg.m;
        p3_next.sa = sat32(ta[39:0]);
        p3_next.sb = sat32(tb[39:0]);
    end

    // post 4: weighted relative speed
    always_comb
    begin
        logic signed [32:0] rel;
        logic signed [32:0] nrel;
        rel  = 33'(p3_reg.sb) - 33'(p3_reg.sa);
        nrel = 33'(p3_reg.sa) - 33'(p3_reg.sb);
        p4_next.c   = p3_reg.c;
        p4_next.ux  = p3_reg.ux;
        p4_next.uy  = p3_reg.uy;
        p4_next.m   = p3_reg.m;
        p4_next.pda = rel * $signed({1'b0, p3_reg.wb});
        p4_next.pdb = nrel * $signed({1'b0, p3_reg.wa});
    end

    // post 5: speed changes
    always_comb
    begin
        logic signed [65:0] ta;
        logic signed [65:0] tb;
        ta = (p4_reg.pda + 66'sd536870912) >>> 30;
        tb = (p4_reg.pdb + 66'sd536870912) >>> 30;
        p5_next.c  = p4_reg.c;
        p5_next.ux = p4_reg.ux;
        p5_next.uy = p4_reg.uy;
        p5_next.m  = p4_reg.m;
        p5_next.da = ta[35:0];
        p5_next.db = tb[35:0];
    end

    // post 6: deltas along the unit vector
    always_comb
    begin
        p6_next.c   = p5_reg.c;
        p6_next.dax = p5_reg.da * p5_reg.ux;
        p6_next.day = p5_reg.da * p5_reg.uy;
        p6_next.dbx = p5_reg.db * p5_reg.ux;
        p6_next.dby = p5_reg.db * p5_reg.uy;
        p6_next.pmx = p5_reg.m * p5_reg.ux;
        p6_next.pmy = p5_reg.m * p5_reg.uy;
    end

    // post 7: apply and saturate, or pass through
    always_comb
    begin
        carry_t             c;
        logic signed [39:0] px;
        logic signed [39:0] py;
        c  = p6_reg.c;
        px = rnd30(p6_reg.pmx);
        py = rnd30(p6_reg.pmy);
        p7_next.collided = c.hit;
        if (c.hit)
        begin
            p7_next.new_pos_a_x = addsat(c.ax, px);
            p7_next.new_pos_a_y = addsat(c.ay, py);
            p7_next.new_vel_a_x = addsat(c.avx, rnd30(p6_reg.dax));
            p7_next.new_vel_a_y = addsat(c.avy, rnd30(p6_reg.day));
            p7_next.new_pos_b_x = addsat(c.bx, -px);
            p7_next.new_pos_b_y = addsat(c.by, -py);
            p7_next.new_vel_b_x = addsat(c.bvx, rnd30(p6_reg.dbx));
            p7_next.new_vel_b_y = addsat(c.bvy, rnd30(p6_reg.dby));
        end
        else
        begin
            p7_next.new_pos_a_x = c.ax;
            p7_next.new_pos_a_y = c.ay;
            p7_next.new_vel_a_x = c.avx;
            p7_next.new_vel_a_y = c.avy;
            p7_next.new_pos_b_x = c.bx;
            p7_next.new_pos_b_y = c.by;
            p7_next.new_vel_b_x = c.bvx;
            p7_next.new_vel_b_y = c.bvy;
        end
    end

    // datapath registers; advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            s3_reg    <= s3_next;
            sq_reg[0] <= sq0_next;
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                sq_reg[k+1] <= sq_step(sq_reg[k]);
            end
            dv_reg[0] <= dv0_next;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    dv_reg[k+1].ln[j] <= lane_step(dv_reg[k].ln[j]);
                end
                dv_reg[k+1].c     <= dv_reg[k].c;
                dv_reg[k+1].d     <= dv_reg[k].d;
                dv_reg[k+1].dzero <= dv_reg[k].dzero;
                dv_reg[k+1].tzero <= dv_reg[k].tzero;
            end
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
            p4_reg <= p4_next;
            p5_reg <= p5_next;
            p6_reg <= p6_next;
            p7_reg <= p7_next;
        end
    end

    // output register and skid entry
    assign push     = en && vld_reg[NSTG-1];
    assign out_fire = out_v_reg && result_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (out_fire)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_v_reg && !out_fire)
            begin
                skid_v_reg <= 1'b1;
            end
            else
            begin
                out_v_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_v_reg && !out_fire)
            begin
                skid_reg <= p7_reg;
            end
            else
            begin
                out_reg <= p7_reg;
            end
        end
    end

    assign result_out.valid   = out_v_reg;
    assign result_out.payload = out_reg;

    `CPCR_ASSERT_HOLD(a_skid_behind_out, clk, rst_n, !skid_v_reg || out_v_reg, "skid full with empty output")
    `CPCR_ASSERT_NEXT(a_skid_kept, clk, rst_n, skid_v_reg && !result_out.ready, skid_v_reg && $stable(skid_reg), "stalled skid entry lost")
    `CPCR_ASSERT_NEXT(a_pipe_frozen, clk, rst_n, !en, $stable(vld_reg), "pipeline moved while held")
    `CPCR_ASSERT_NEXT(a_push_stalled, clk, rst_n, push && out_v_reg && !result_out.ready, skid_v_reg, "result dropped on stall")

endmodule

// File: sim/tb.sv
// Testbench for circle_pair_collision_resolver_core: directed table then random pairs,
// checked against a behavioral predictor of the elastic collision arithmetic.
// Depends on cpcr_pkg, the pair, result and cfg channel interfaces and the core.
`timescale 1ns / 1ps

module tb;
    import cpcr_pkg::*;

    localparam int LATENCY = 76;
    localparam int N_RANDOM = 750;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    cpcr_pair_if   pair_ch();
    cpcr_result_if res_ch();
    cpcr_cfg_if    cfg_ch();

    circle_pair_collision_resolver_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .pair_in(pair_ch.sink),
        .result_out(res_ch.source),
        .cfg(cfg_ch.sink)
    );

    logic [15:0] nudge_x_q = NUDGE_RESET;
    logic [15:0] nudge_y_q = NUDGE_RESET;

    result_t expected_q[$];
    int      errors = 0;
    bit      idle_on = 1'b1;
    bit      hold_off = 1'b0;

    pair_t   dir_pair[$];
    result_t dir_res[$];
    bit      dir_typed[$];

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint floor_shift(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint round_shift(longint x, int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic [63:0] mag_sq(longint a);
        logic [63:0] m;
        m = (a < 0) ? -a : a;
        return m * m;
    endfunction

    function automatic logic [63:0] dist_sq(longint dx, longint dy);
        logic [63:0] p, q;
        p = mag_sq(dx);
        q = mag_sq(dy);
        if (p > 64'hFFFF_FFFF_FFFF_FFFF - q)
            return 64'hFFFF_FFFF_FFFF_FFFF;
        return p + q;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unit_part(longint c, logic [63:0] d);
        logic [63:0] m, q;
        m = (c < 0) ? -c : c;
        q = ((m << 30) + d / 2) / d;
        return (c < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint mass_weight(logic [63:0] m, logic [63:0] tot);
        if (tot == 0)
            return 64'sd1 <<< 30;
        return longint'(((m << 31) + tot / 2) / tot);
    endfunction

    function automatic result_t resolve_pair(pair_t p);
        result_t r;
        longint ax, ay, avx, avy, bx, by, bvx, bvy, dx, dy;
        longint ux, uy, sa, sb, wa, wb, rel, da, db, m, px, py;
        logic [63:0] ma, mb, rs, d, tot;
        bit hit;
        ax = p.pos_a_x; ay = p.pos_a_y; avx = p.vel_a_x; avy = p.vel_a_y;
        bx = p.pos_b_x; by = p.pos_b_y; bvx = p.vel_b_x; bvy = p.vel_b_y;
        ma = p.mass_a; mb = p.mass_b;
        rs = 64'(p.radius_a) + 64'(p.radius_b);
        dx = ax - bx;
        dy = ay - by;
        hit = dist_sq(dx, dy) <= rs * rs;
        if (hit)
        begin
            ux = 0;
            uy = 0;
            if (dx == 0 && dy == 0)
            begin
                bx = sat32(bx + longint'(nudge_x_q));
                by = sat32(by + longint'(nudge_y_q));
                dx = ax - bx;
                dy = ay - by;
            end
            d = int_sqrt(dist_sq(dx, dy));
            if (d != 0)
            begin
                ux = unit_part(dx, d);
                uy = unit_part(dy, d);
            end
            sa = sat32(round_shift(avx * ux + avy * uy, 30));
            sb = sat32(round_shift(bvx * ux + bvy * uy, 30));
            tot = ma + mb;
            wa = mass_weight(ma, tot);
            wb = mass_weight(mb, tot);
            rel = sb - sa;
            da = round_shift(rel * wb, 30);
            db = round_shift(-rel * wa, 30);
            avx = sat32(avx + round_shift(da * ux, 30));
            avy = sat32(avy + round_shift(da * uy, 30));
            bvx = sat32(bvx + round_shift(db * ux, 30));
            bvy = sat32(bvy + round_shift(db * uy, 30));
            m = floor_shift(longint'(rs) - longint'(d), 2) + 32768;
            px = round_shift(m * ux, 30);
            py = round_shift(m * uy, 30);
            ax = sat32(ax + px);
            ay = sat32(ay + py);
            bx = sat32(bx - px);
            by = sat32(by - py);
        end
        r.collided = hit;
        r.new_pos_a_x = ax[31:0]; r.new_pos_a_y = ay[31:0];
        r.new_vel_a_x = avx[31:0]; r.new_vel_a_y = avy[31:0];
        r.new_pos_b_x = bx[31:0]; r.new_pos_b_y = by[31:0];
        r.new_vel_b_x = bvx[31:0]; r.new_vel_b_y = bvy[31:0];
        return r;
    endfunction

    function automatic pair_t mk_pair(int ax, int ay, int avx, int avy, int unsigned ma,
                                      int unsigned ra, int bx, int by, int bvx, int bvy,
                                      int unsigned mb, int unsigned rb);
        pair_t p;
        p.pos_a_x = ax; p.pos_a_y = ay; p.vel_a_x = avx; p.vel_a_y = avy;
        p.mass_a = ma; p.radius_a = ra[30:0];
        p.pos_b_x = bx; p.pos_b_y = by; p.vel_b_x = bvx; p.vel_b_y = bvy;
        p.mass_b = mb; p.radius_b = rb[30:0];
        return p;
    endfunction

    function automatic result_t passthru(pair_t p);
        result_t r;
        r.collided = 1'b0;
        r.new_pos_a_x = p.pos_a_x; r.new_pos_a_y = p.pos_a_y;
        r.new_vel_a_x = p.vel_a_x; r.new_vel_a_y = p.vel_a_y;
        r.new_pos_b_x = p.pos_b_x; r.new_pos_b_y = p.pos_b_y;
        r.new_vel_b_x = p.vel_b_x; r.new_vel_b_y = p.vel_b_y;
        return r;
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        int unsigned sc, k;
        k = $urandom_range(0, 9);
        sc = (k < 2) ? 32'hFFFF_FFFF : ((k < 5) ? 32'h00FF_FFFF : 32'h000F_FFFF);
        p.pos_a_x = $urandom & sc; p.pos_a_y = $urandom & sc;
        p.pos_b_x = $urandom & sc; p.pos_b_y = $urandom & sc;
        if (sc != 32'hFFFF_FFFF)
        begin
            p.pos_a_x = p.pos_a_x - (sc >> 1); p.pos_a_y = p.pos_a_y - (sc >> 1);
            p.pos_b_x = p.pos_b_x - (sc >> 1); p.pos_b_y = p.pos_b_y - (sc >> 1);
        end
        if ($urandom_range(0, 15) == 0)
        begin
            p.pos_b_x = p.pos_a_x;
            p.pos_b_y = p.pos_a_y;
        end
        p.vel_a_x = $urandom; p.vel_a_y = $urandom;
        p.vel_b_x = $urandom; p.vel_b_y = $urandom;
        if ($urandom_range(0, 1))
        begin
            p.vel_a_x = p.vel_a_x >>> 12; p.vel_a_y = p.vel_a_y >>> 12;
            p.vel_b_x = p.vel_b_x >>> 12; p.vel_b_y = p.vel_b_y >>> 12;
        end
        p.mass_a = $urandom; p.mass_b = $urandom;
        if ($urandom_range(0, 1))
        begin
            p.mass_a = (p.mass_a >> $urandom_range(0, 31)) | 1;
            p.mass_b = (p.mass_b >> $urandom_range(0, 31)) | 1;
        end
        if (p.mass_a == 0) p.mass_a = 1;
        if (p.mass_b == 0) p.mass_b = 1;
        p.radius_a = 31'($urandom);
        p.radius_b = 31'($urandom);
        if (k >= 2 && $urandom_range(0, 3) != 0)
        begin
            p.radius_a = p.radius_a & sc[30:0];
            p.radius_b = p.radius_b & sc[30:0];
        end
        return p;
    endfunction

    initial
    begin
        pair_ch.valid = 1'b0;
        pair_ch.payload = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_NUDGE_X;
        cfg_ch.data = '0;
    end

    task automatic send_pair(pair_t p);
        int g;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            g = $urandom_range(1, 13);
            pair_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        pair_ch.valid <= 1'b1;
        pair_ch.payload <= p;
        @(posedge clk);
        while (!pair_ch.ready)
            @(posedge clk);
        expected_q.push_back(resolve_pair(p));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_NUDGE_X)
            nudge_x_q = val;
        else
            nudge_y_q = val;
        @(posedge clk);
    endtask

    task automatic drain();
        pair_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, res_ch.payload);
                errors++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (exp_r.collided !== res_ch.payload.collided)
                    $display("%0t: collided exp %b got %b", $time, exp_r.collided,
                             res_ch.payload.collided);
                if (exp_r.new_pos_a_x !== res_ch.payload.new_pos_a_x)
                    $display("%0t: new_pos_a_x exp %h got %h", $time, exp_r.new_pos_a_x,
                             res_ch.payload.new_pos_a_x);
                if (exp_r.new_pos_a_y !== res_ch.payload.new_pos_a_y)
                    $display("%0t: new_pos_a_y exp %h got %h", $time, exp_r.new_pos_a_y,
                             res_ch.payload.new_pos_a_y);
                if (exp_r.new_vel_a_x !== res_ch.payload.new_vel_a_x)
                    $display("%0t: new_vel_a_x exp %h got %h", $time, exp_r.new_vel_a_x,
                             res_ch.payload.new_vel_a_x);
                if (exp_r.new_vel_a_y !== res_ch.payload.new_vel_a_y)
                    $display("%0t: new_vel_a_y exp %h got %h", $time, exp_r.new_vel_a_y,
                             res_ch.payload.new_vel_a_y);
                if (exp_r.new_pos_b_x !== res_ch.payload.new_pos_b_x)
                    $display("%0t: new_pos_b_x exp %h got %h", $time, exp_r.new_pos_b_x,
                             res_ch.payload.new_pos_b_x);
                if (exp_r.new_pos_b_y !== res_ch.payload.new_pos_b_y)
                    $display("%0t: new_pos_b_y exp %h got %h", $time, exp_r.new_pos_b_y,
                             res_ch.payload.new_pos_b_y);
                if (exp_r.new_vel_b_x !== res_ch.payload.new_vel_b_x)
                    $display("%0t: new_vel_b_x exp %h got %h", $time, exp_r.new_vel_b_x,
                             res_ch.payload.new_vel_b_x);
                if (exp_r.new_vel_b_y !== res_ch.payload.new_vel_b_y)
                    $display("%0t: new_vel_b_y exp %h got %h", $time, exp_r.new_vel_b_y,
                             res_ch.payload.new_vel_b_y);
                if (exp_r !== res_ch.payload)
                    errors++;
            end
        end
    end

    // hold ready low in random bursts, or for a long stretch on request
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                res_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                g = $urandom_range(1, 13);
                res_ch.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        pair_t p;
        int i;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no overlap: far apart with extreme field values, then a gap of one radius
        p = mk_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 1, 0);
        dir_pair.push_back(p); dir_res.push_back(passthru(p)); dir_typed.push_back(1);
        p = mk_pair(0, 0, 5, -5, 32'h10000, 32'h10000, 32'h30000, 0, 0, 0, 32'h10000,
                    32'h10000);
        dir_pair.push_back(p); dir_res.push_back(passthru(p)); dir_typed.push_back(1);
        // head-on touch, equal masses
        p = mk_pair(0, 0, 32'h10000, 0, 32'h10000, 32'h10000, 32'h20000, 0, -32'h10000, 0,
                    32'h10000, 32'h10000);
        dir_pair.push_back(p); dir_res.push_back('0); dir_typed.push_back(0);
        // coincident centers, nudged by the reset nudge
        p = mk_pair(100, 200, 32'h1234, -32'h4321, 32'h20000, 32'h8000, 100, 200, 0, 0,
                    32'h10000, 32'h8000);
        dir_pair.push_back(p); dir_res.push_back('0); dir_typed.push_back(0);
        // coincident at saturation corner: nudge saturates, still coincident
        p = mk_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 7, 9, 3, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    11, 13, 5, 0);
        dir_pair.push_back(p); dir_res.push_back('0); dir_typed.push_back(0);
        // huge radii, extreme velocities and masses
        p = mk_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        dir_pair.push_back(p); dir_res.push_back('0); dir_typed.push_back(0);
        // masses whose sum carries past 32 bits
        p = mk_pair(0, 0, 32'h10000, 32'h5000, 32'h8000_0000, 32'h20000, 32'h10000,
                    32'h8000, 0, 0, 32'h8000_0000, 32'h20000);
        dir_pair.push_back(p); dir_res.push_back('0); dir_typed.push_back(0);
        // negative overlap after nudge: tiny radii on coincident centers
        p = mk_pair(-500, 700, 1, 2, 1, 1, -500, 700, 3, 4, 32'hFFFF_FFFF, 0);
        dir_pair.push_back(p); dir_res.push_back('0); dir_typed.push_back(0);
        p = mk_pair(0, 0, 0, 0, 1, 1, 1, 1, 0, 0, 1, 1);
        dir_pair.push_back(p); dir_res.push_back('0); dir_typed.push_back(0);

        for (i = 0; i < dir_pair.size(); i++)
        begin
            send_pair(dir_pair[i]);
            if (dir_typed[i])
            begin
                if (dir_res[i] !== expected_q[expected_q.size() - 1])
                begin
                    $display("%0t: table row %0d exp %h got %h", $time, i, dir_res[i],
                             expected_q[expected_q.size() - 1]);
                    errors++;
                end
                expected_q[expected_q.size() - 1] = dir_res[i];
            end
        end
        drain();

        write_reg(REG_NUDGE_X, 16'hFFFF);
        write_reg(REG_NUDGE_Y, 16'h0000);
        send_pair(dir_pair[3]);
        send_pair(dir_pair[4]);
        send_pair(dir_pair[7]);
        drain();
        write_reg(REG_NUDGE_X, 16'h0001);
        write_reg(REG_NUDGE_Y, 16'hFFFF);
        send_pair(dir_pair[3]);
        send_pair(dir_pair[7]);
        drain();

        for (i = 0; i < N_RANDOM; i++)
        begin
            if (i % 150 == 0 && i != 0)
            begin
                drain();
                write_reg(REG_NUDGE_X, 16'($urandom_range(1, 65535)));
                write_reg(REG_NUDGE_Y, 16'($urandom));
            end
            if (i == 300)
                hold_off = 1'b1;
            if (i == N_RANDOM - 100)
                idle_on = 1'b0;
            send_pair(rand_pair());
        end
        pair_ch.valid <= 1'b0;

        i = 0;
        while (expected_q.size() != 0 && i < 100000)
        begin
            @(posedge clk);
            i++;
        end
        repeat (LATENCY + 4) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/cpcr_pkg.sv
rtl/core/cpcr_pair_if.sv
rtl/core/cpcr_result_if.sv
rtl/core/cpcr_cfg_if.sv
rtl/core/circle_pair_collision_resolver_core.sv
sim/tb.sv
